@@ hw/rtl/ntoc_pkg.sv @@
// ntoc_pkg: shared types, constants and the count table for the note to
// oscillator count block. No dependencies.
`timescale 1ns / 1ps

package ntoc_pkg;

  localparam int NoteW  = 7;
  localparam int BendW  = 14;
  localparam int CountW = 16;
  localparam int PitchW = 16;
  localparam int ShiftW = 4;
  localparam int IdxW   = 7;
  localparam int FracW  = 8;
  localparam int ProdW  = CountW + FracW;

  localparam logic signed [PitchW-1:0] OctaveSteps = PitchW'(12 << 7);
  localparam logic signed [PitchW-1:0] LowestPitch = PitchW'(16 << 7);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LOOKUP,
    ST_INTERP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic reduce;
    logic lookup;
    logic interp;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
  } dp_status_t;

  function automatic logic [CountW-1:0] count_table(input logic [IdxW-1:0] idx);
    logic [CountW-1:0] v;
    case (idx)
      7'd0:  v = 16'd60675;  7'd1:  v = 16'd60238;  7'd2:  v = 16'd59805;
      7'd3:  v = 16'd59374;  7'd4:  v = 16'd58947;  7'd5:  v = 16'd58523;
      7'd6:  v = 16'd58102;  7'd7:  v = 16'd57684;  7'd8:  v = 16'd57269;
      7'd9:  v = 16'd56857;  7'd10: v = 16'd56448;  7'd11: v = 16'd56042;
      7'd12: v = 16'd55639;  7'd13: v = 16'd55239;  7'd14: v = 16'd54841;
      7'd15: v = 16'd54447;  7'd16: v = 16'd54055;  7'd17: v = 16'd53666;
      7'd18: v = 16'd53280;  7'd19: v = 16'd52897;  7'd20: v = 16'd52516;
      7'd21: v = 16'd52138;  7'd22: v = 16'd51763;  7'd23: v = 16'd51391;
      7'd24: v = 16'd51021;  7'd25: v = 16'd50654;  7'd26: v = 16'd50290;
      7'd27: v = 16'd49928;  7'd28: v = 16'd49569;  7'd29: v = 16'd49212;
      7'd30: v = 16'd48858;  7'd31: v = 16'd48506;  7'd32: v = 16'd48157;
      7'd33: v = 16'd47811;  7'd34: v = 16'd47467;  7'd35: v = 16'd47125;
      7'd36: v = 16'd46786;  7'd37: v = 16'd46450;  7'd38: v = 16'd46116;
      7'd39: v = 16'd45784;  7'd40: v = 16'd45455;  7'd41: v = 16'd45128;
      7'd42: v = 16'd44803;  7'd43: v = 16'd44481;  7'd44: v = 16'd44161;
      7'd45: v = 16'd43843;  7'd46: v = 16'd43527;  7'd47: v = 16'd43214;
      7'd48: v = 16'd42903;  7'd49: v = 16'd42595;  7'd50: v = 16'd42288;
      7'd51: v = 16'd41984;  7'd52: v = 16'd41682;  7'd53: v = 16'd41382;
      7'd54: v = 16'd41084;  7'd55: v = 16'd40789;  7'd56: v = 16'd40495;
      7'd57: v = 16'd40204;  7'd58: v = 16'd39915;  7'd59: v = 16'd39628;
      7'd60: v = 16'd39343;  7'd61: v = 16'd39060;  7'd62: v = 16'd38779;
      7'd63: v = 16'd38500;  7'd64: v = 16'd38223;  7'd65: v = 16'd37948;
      7'd66: v = 16'd37675;  7'd67: v = 16'd37404;  7'd68: v = 16'd37134;
      7'd69: v = 16'd36867;  7'd70: v = 16'd36602;  7'd71: v = 16'd36339;
      7'd72: v = 16'd36077;  7'd73: v = 16'd35818;  7'd74: v = 16'd35560;
      7'd75: v = 16'd35304;  7'd76: v = 16'd35050;  7'd77: v = 16'd34798;
      7'd78: v = 16'd34548;  7'd79: v = 16'd34299;  7'd80: v = 16'd34052;
      7'd81: v = 16'd33807;  7'd82: v = 16'd33564;  7'd83: v = 16'd33323;
      7'd84: v = 16'd33083;  7'd85: v = 16'd32845;  7'd86: v = 16'd32609;
      7'd87: v = 16'd32374;  7'd88: v = 16'd32141;  7'd89: v = 16'd31910;
      7'd90: v = 16'd31680;  7'd91: v = 16'd31452;  7'd92: v = 16'd31226;
      7'd93: v = 16'd31002;  7'd94: v = 16'd30779;  7'd95: v = 16'd30557;
      7'd96: v = 16'd30337;
      default: v = 16'd30337;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/ntoc_if.sv @@
// ntoc_in_if / ntoc_out_if: valid/ready channels for note input and count output.
// Depends on ntoc_pkg.
`timescale 1ns / 1ps

interface ntoc_in_if import ntoc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [NoteW-1:0]  note;
  logic signed [BendW-1:0]  pitch_bend;

  modport source (output valid, output note, output pitch_bend, input ready);
  modport sink   (input valid, input note, input pitch_bend, output ready);
endinterface

interface ntoc_out_if import ntoc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] osc_count;

  modport source (output valid, output osc_count, input ready);
  modport sink   (input valid, input osc_count, output ready);
endinterface

@@ hw/rtl/ntoc_ctrl.sv @@
// ntoc_ctrl: sequencing state machine and output valid flag.
// Depends on ntoc_pkg.
`timescale 1ns / 1ps

module ntoc_ctrl import ntoc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (status_i.in_range) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: state_d = ST_INTERP;
      ST_INTERP: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      ST_REDUCE: cmd_o.reduce = !status_i.in_range;
      ST_LOOKUP: cmd_o.lookup = 1'b1;
      ST_INTERP: cmd_o.interp = 1'b1;
      ST_FINISH: cmd_o.finish = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.finish) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/ntoc_dp.sv @@
// ntoc_dp: pitch, octave reduction, table interpolation and shift datapath.
// Depends on ntoc_pkg.
`timescale 1ns / 1ps

module ntoc_dp import ntoc_pkg::*; (
  input  logic                    clk_i,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o,
  input  logic        [NoteW-1:0] note_i,
  input  logic signed [BendW-1:0] pitch_bend_i,
  output logic       [CountW-1:0] osc_count_o
);

  logic signed [PitchW-1:0] pitch_q, pitch_d;
  logic        [ShiftW-1:0] shifts_q, shifts_d;
  logic        [CountW-1:0] count_q, next_q;
  logic        [FracW-1:0]  frac_q;
  logic        [ProdW-1:0]  prod_q;
  logic        [CountW-1:0] res_q;

  logic signed [BendW-1:0]  bend_sh;
  logic signed [PitchW-1:0] note_ext, bend_ext, pitch_init;
  logic                     pitch_neg, pitch_ge;
  logic        [IdxW-1:0]   idx;
  logic        [CountW-1:0] diff, interp;

  assign bend_sh    = pitch_bend_i >>> 5;
  assign bend_ext   = {{(PitchW-BendW){bend_sh[BendW-1]}}, bend_sh};
  assign note_ext   = {{(PitchW-NoteW-7){1'b0}}, note_i, 7'b0};
  assign pitch_init = note_ext + bend_ext - LowestPitch;

  assign pitch_neg  = pitch_q[PitchW-1];
  assign pitch_ge   = !pitch_neg && (pitch_q >= OctaveSteps);
  assign status_o.in_range = !pitch_neg && !pitch_ge;

  always_comb begin
    pitch_d  = pitch_q;
    shifts_d = shifts_q;
    if (cmd_i.load) begin
      pitch_d  = pitch_init;
      shifts_d = '0;
    end else if (cmd_i.reduce) begin
      if (pitch_neg) begin
        pitch_d = pitch_q + OctaveSteps;
      end else if (pitch_ge) begin
        pitch_d  = pitch_q - OctaveSteps;
        shifts_d = shifts_q + ShiftW'(1);
      end
    end
  end

  assign idx    = pitch_q[10:4];
  assign diff   = count_q - next_q;
  assign interp = count_q - prod_q[ProdW-1:FracW];

  always_ff @(posedge clk_i) begin
    pitch_q  <= pitch_d;
    shifts_q <= shifts_d;
    if (cmd_i.lookup) begin
      count_q <= count_table(idx);
      next_q  <= count_table(IdxW'(idx + IdxW'(1)));
      frac_q  <= {pitch_q[3:0], 4'b0};
    end
    if (cmd_i.interp) prod_q <= diff * frac_q;
    if (cmd_i.finish) res_q <= interp >> shifts_q;
  end

  assign osc_count_o = res_q;

endmodule

@@ hw/rtl/note_to_oscillator_count_top.sv @@
// note_to_oscillator_count_top: note and pitch bend to oscillator timer count.
// Depends on ntoc_pkg, ntoc_if, ntoc_ctrl, ntoc_dp.
//
//   Channel      Dir  Payload                         Handshake
//   note_in_i    in   note[6:0], pitch_bend[13:0]     valid/ready
//   count_out_o  out  osc_count[15:0]                 valid/ready
//
// One transaction at a time, run through REDUCE, LOOKUP, INTERP and FINISH;
// time in REDUCE is set by the octave reduction loop (one add or subtract
// of 1536 per cycle, up to 9). The next input is taken only back in idle.
// Reset clears the controller and output valid; the datapath holds no reset.
// The result sits in an output register; the next input is taken while it
// waits, and the controller stalls before writing the register again.
`timescale 1ns / 1ps

module note_to_oscillator_count_top import ntoc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  ntoc_in_if.sink       note_in_i,
  ntoc_out_if.source    count_out_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ntoc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (note_in_i.valid),
    .in_ready_o  (note_in_i.ready),
    .out_valid_o (count_out_o.valid),
    .out_ready_i (count_out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ntoc_dp u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .note_i       (note_in_i.note),
    .pitch_bend_i (note_in_i.pitch_bend),
    .osc_count_o  (count_out_o.osc_count)
  );

endmodule
